FILE: rtl/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared constants and types of the bounded random number core: generator
// constants, controller states and the command/status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbr_pkg;

    // generator geometry
    localparam int STATE_W  = 48;
    localparam int DRAW_W   = 31;
    localparam int CHUNK_W  = 16;
    localparam int TDATA_W  = 32;

    // linear congruential constants
    localparam logic [STATE_W-1:0] LCG_MULT  = 48'h0005_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_ADD   = 48'h0000_0000_000B;
    localparam logic [STATE_W-1:0] SEED_INIT = 48'h0043_4C4F_5544 ^ LCG_MULT;

    // multiply steps per draw, one seed chunk each
    localparam int LCG_STEPS = STATE_W / CHUNK_W;
    localparam int LCG_CNT_W = $clog2(LCG_STEPS);
    localparam logic [LCG_CNT_W-1:0] LCG_LAST = LCG_CNT_W'(LCG_STEPS - 1);

    // restoring divider, one quotient bit per step
    localparam int DIV_STEPS = DRAW_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_DIV,
        ST_CHECK,
        ST_HOLD
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_bound;
        logic lcg_go;
        logic div_go;
        logic load_result;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic lcg_done;
        logic div_done;
        logic pow2;
        logic reject;
    } stat_t;

endpackage

FILE: rtl/lcg48_bounded_random_core.sv
// ----------------------------------------------------------------------------
// lcg48_bounded_random_core
// Bounded random number core on a 48-bit linear congruential state.
//
//   channel   dir   handshake          payload
//   s_*       in    s_tvalid/s_tready  s_tdata[30:0] bound
//   m_*       out   m_tvalid/m_tready  m_tdata[30:0] value
//
// A power-of-two (or zero) bound runs 3 generator multiply steps, one
// handoff and one load; the next request can be taken in the same cycle
// as the result shows.
// Any other bound runs each draw through 3 generator steps, one handoff,
// 31 remainder steps, one handoff and one tail test, repeats the draw while
// the tail test rejects, then loads the result; the next request can be
// taken in the same cycle as the result shows.
// The 31-step remainder unit is the longest part for non-power-of-two bounds.
// Reset loads the fixed seed; there is no clearing pass.
// A stalled result sits in the output register while the next request
// is taken; a new result waits until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcg48_bounded_random_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lbr_pkg::TDATA_W-1:0] s_tdata,   // [30:0] bound, [31] pad
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lbr_pkg::TDATA_W-1:0] m_tdata    // [30:0] value, [31] pad
);
    import lbr_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [DRAW_W-1:0] result;

    lbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lbr_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .bound_in (s_tdata[DRAW_W-1:0]),
        .result   (result)
    );

    // pad to whole bytes
    assign m_tdata = {{(TDATA_W-DRAW_W){1'b0}}, result};

endmodule

FILE: rtl/lbr_lcg.sv
// ----------------------------------------------------------------------------
// lbr_lcg
// 48-bit linear congruential generator. The state multiply is split into
// three 16-bit chunk products that are accumulated in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbr_lcg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic [lbr_pkg::DRAW_W-1:0] draw,
    output logic                      done
);
    import lbr_pkg::*;

    logic [STATE_W-1:0]   seed_reg;
    logic [STATE_W-1:0]   seed_next;
    logic [STATE_W-1:0]   acc_reg;
    logic [STATE_W-1:0]   acc_next;
    logic [LCG_CNT_W-1:0] cnt_reg;
    logic [LCG_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CHUNK_W-1:0]   chunk;
    logic [STATE_W-1:0]   prod;
    logic [STATE_W-1:0]   part;

    // chunk product, shifted to its place, truncated mod 2^48
    always_comb
    begin
        chunk = '0;
        part  = '0;
        prod  = STATE_W'(chunk) * LCG_MULT;
        unique case (cnt_reg)
            2'd0:
            begin
                chunk = seed_reg[CHUNK_W-1:0];
                prod  = STATE_W'(chunk) * LCG_MULT;
                part  = prod;
            end
            2'd1:
            begin
                chunk = seed_reg[2*CHUNK_W-1:CHUNK_W];
                prod  = STATE_W'(chunk) * LCG_MULT;
                part  = prod << CHUNK_W;
            end
            2'd2:
            begin
                chunk = seed_reg[3*CHUNK_W-1:2*CHUNK_W];
                prod  = STATE_W'(chunk) * LCG_MULT;
                part  = prod << (2 * CHUNK_W);
            end
            default:
            begin
                chunk = '0;
                part  = '0;
            end
        endcase
    end

    // step sequencing
    always_comb
    begin
        seed_next = seed_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = LCG_ADD;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LCG_LAST)
            begin
                seed_next = acc_reg + part;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_INIT;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            seed_reg <= seed_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // accumulator
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign draw = seed_reg[STATE_W-1:STATE_W-DRAW_W];
    assign done = done_reg;

endmodule

FILE: rtl/lbr_div.sv
// ----------------------------------------------------------------------------
// lbr_div
// Restoring divider that yields the remainder of a 31-bit draw by the
// bound, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbr_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lbr_pkg::DRAW_W-1:0] dividend,
    input  logic [lbr_pkg::DRAW_W-1:0] divisor,
    output logic [lbr_pkg::DRAW_W-1:0] rem,
    output logic                       done
);
    import lbr_pkg::*;

    logic [DRAW_W-1:0]    rem_reg;
    logic [DRAW_W-1:0]    rem_next;
    logic [DRAW_W-1:0]    dvd_reg;
    logic [DRAW_W-1:0]    dvd_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DRAW_W:0]      trial;
    logic [DRAW_W:0]      diff;

    // shift in next dividend bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DRAW_W-1]};
        diff  = trial - {1'b0, divisor};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = diff[DRAW_W-1:0];
            end
            else
            begin
                rem_next = trial[DRAW_W-1:0];
            end
            dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

FILE: rtl/lbr_datapath.sv
// ----------------------------------------------------------------------------
// lbr_datapath
// Bound register, generator, remainder unit, power-of-two scaling,
// rejection test and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbr_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lbr_pkg::cmd_t              cmd,
    output lbr_pkg::stat_t             stat,
    input  logic [lbr_pkg::DRAW_W-1:0] bound_in,
    output logic [lbr_pkg::DRAW_W-1:0] result
);
    import lbr_pkg::*;

    logic [DRAW_W-1:0]   bound_reg;
    logic [DRAW_W-1:0]   result_reg;
    logic [DRAW_W-1:0]   draw;
    logic [DRAW_W-1:0]   rem;
    logic [2*DRAW_W-1:0] scale_prod;
    logic [DRAW_W+1:0]   tail_sum;
    logic                lcg_done;
    logic                div_done;

    lbr_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.lcg_go),
        .draw  (draw),
        .done  (lcg_done)
    );

    lbr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_go),
        .dividend (draw),
        .divisor  (bound_reg),
        .rem      (rem),
        .done     (div_done)
    );

    // power-of-two bound: high bits of bound * draw
    assign scale_prod = (2*DRAW_W)'(bound_reg) * (2*DRAW_W)'(draw);

    // biased tail test: draw - rem + bound - 1 reaches 2^31
    assign tail_sum = {2'b00, draw} - {2'b00, rem} + {2'b00, bound_reg} - 1'b1;

    always_comb
    begin
        stat.lcg_done = lcg_done;
        stat.div_done = div_done;
        stat.pow2     = ((bound_reg & (bound_reg - 1'b1)) == '0);
        stat.reject   = (tail_sum[DRAW_W+1:DRAW_W] != 2'b00);
    end

    // bound and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_bound)
        begin
            bound_reg <= bound_in;
        end
        if (cmd.load_result)
        begin
            if (stat.pow2)
            begin
                result_reg <= scale_prod[2*DRAW_W-1:DRAW_W];
            end
            else
            begin
                result_reg <= rem;
            end
        end
    end

    assign result = result_reg;

endmodule

FILE: rtl/lbr_ctrl.sv
// ----------------------------------------------------------------------------
// lbr_ctrl
// Controller: takes a request, runs draws and the remainder unit, repeats
// rejected draws and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output lbr_pkg::cmd_t  cmd,
    input  lbr_pkg::stat_t stat
);
    import lbr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_bound = 1'b1;
                    cmd.lcg_go     = 1'b1;
                    state_next     = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (stat.lcg_done)
                begin
                    if (stat.pow2)
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        cmd.div_go = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.reject)
                begin
                    cmd.lcg_go = 1'b1;
                    state_next = ST_DRAW;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/lbr_checker.sv
// ----------------------------------------------------------------------------
// lbr_checker
// Port-level checks of the bounded random number core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [lbr_pkg::TDATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lbr_pkg::TDATA_W-1:0] m_tdata
);
    import lbr_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a request keeps the core busy for at least the generator steps
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("request taken during a draw");

    // a new result appears only as the core returns to idle
    a_rose_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while core busy");

    // pad bit of the result stays clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[TDATA_W-1] == 1'b0))
        else $error("result pad bit set");

endmodule

bind lcg48_bounded_random_core lbr_checker u_lbr_checker (.*);
